@@ hdl/tsp_pkg.sv @@
package tsp_pkg;

   localparam int SEC_W  = 63;
   localparam int FRAC_W = 30;
   localparam int STAT_W = 3;
   localparam int FCNT_W = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_POINT = 8'd46;

   localparam logic [FCNT_W-1:0] NS_DIGITS = 4'd9;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_DIGIT = 2'd0;
   localparam kind_type KIND_POINT = 2'd1;
   localparam kind_type KIND_JUNK  = 2'd2;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_NO_POINT     = 3'd1;
   localparam status_type ST_JUNK_DIGIT   = 3'd2;
   localparam status_type ST_SECOND_POINT = 3'd3;
   localparam status_type ST_TOO_LONG     = 3'd4;
   localparam status_type ST_OVERFLOW     = 3'd5;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       last;
   } item_type;

   function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] idx);
      logic [FRAC_W-1:0] res;
      unique case (idx)
         4'd0:    res = 30'd1;
         4'd1:    res = 30'd10;
         4'd2:    res = 30'd100;
         4'd3:    res = 30'd1000;
         4'd4:    res = 30'd10000;
         4'd5:    res = 30'd100000;
         4'd6:    res = 30'd1000000;
         4'd7:    res = 30'd10000000;
         4'd8:    res = 30'd100000000;
         4'd9:    res = 30'd1000000000;
         default: res = 30'd0;
      endcase
      return res;
   endfunction

endpackage

@@ hdl/tsp_front.sv @@
module tsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] char_in
   input  logic              req_tlast,
   output logic              item_valid,
   output tsp_pkg::item_type item,
   input  logic              item_pop
);
   import tsp_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   item_type          q_mem [QDEPTH];
   logic [QIDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QIDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push;
   item_type          new_item;

   always_comb begin
      new_item.digit = 4'(req_tdata - CHAR_ZERO);
      new_item.last  = req_tlast;
      if (req_tdata >= CHAR_ZERO && req_tdata <= CHAR_NINE) begin
         new_item.kind = KIND_DIGIT;
      end else if (req_tdata == CHAR_POINT) begin
         new_item.kind = KIND_POINT;
      end else begin
         new_item.kind = KIND_JUNK;
      end
   end

   assign req_tready = (cnt_ff != QCNT_W'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != '0);
   assign item       = q_mem[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = item_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = QCNT_W'(cnt_ff + QCNT_W'(push) - QCNT_W'(item_pop));

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ hdl/tsp_back.sv @@
module tsp_back #(
   parameter int MAX_CHARS       = 30,
   parameter int FRACTION_DIGITS = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  tsp_pkg::item_type item,
   output logic              item_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [95:0]       rsp_tdata
);
   import tsp_pkg::*;

   localparam int CNT_W = $clog2(MAX_CHARS + 2);

   logic [SEC_W-1:0]  sec_ff, sec_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic              point_ff, point_in;
   logic              lwd_ff, lwd_in;
   status_type        err_ff, err_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              fin_valid_ff, fin_valid_in;
   status_type        fin_stat_ff, fin_stat_in;
   logic [SEC_W-1:0]  fin_sec_ff, fin_sec_in;
   logic [FRAC_W-1:0] fin_frac_ff, fin_frac_in;
   logic [FCNT_W-1:0] fin_k_ff, fin_k_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_stat_ff, rsp_stat_in;
   logic [SEC_W-1:0]  rsp_sec_ff, rsp_sec_in;
   logic [FRAC_W-1:0] rsp_ns_ff, rsp_ns_in;

   logic              out_ready, fin_ready, take_last;
   logic [SEC_W+3:0]  sec_wide;
   logic [FRAC_W+3:0] frac_wide;
   logic              sec_ovf;
   logic [SEC_W-1:0]  u_sec;
   logic [FRAC_W-1:0] u_frac;
   logic [FCNT_W-1:0] u_fcnt;
   logic              u_point, u_lwd;
   status_type        u_err, u_stat;
   logic [CNT_W-1:0]  u_cnt;
   logic [2*FRAC_W-1:0] ns_prod;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign fin_ready = !fin_valid_ff || out_ready;
   assign item_pop  = item_valid && (!item.last || fin_ready);
   assign take_last = item_pop && item.last;

   assign sec_wide  = ({4'b0, sec_ff} << 3) + ({4'b0, sec_ff} << 1)
                    + (SEC_W+4)'(item.digit);
   assign sec_ovf   = |sec_wide[SEC_W+3:SEC_W];
   assign frac_wide = ({4'b0, frac_ff} << 3) + ({4'b0, frac_ff} << 1)
                    + (FRAC_W+4)'(item.digit);

   always_comb begin
      u_sec   = sec_ff;
      u_frac  = frac_ff;
      u_fcnt  = fcnt_ff;
      u_point = point_ff;
      u_lwd   = lwd_ff;
      u_err   = err_ff;
      u_cnt   = (cnt_ff <= CNT_W'(MAX_CHARS)) ? cnt_ff + 1'b1 : cnt_ff;
      if (err_ff == ST_OK) begin
         unique case (item.kind)
            KIND_DIGIT: begin
               if (!lwd_ff) begin
                  u_err = ST_JUNK_DIGIT;
               end else if (!point_ff) begin
                  if (sec_ovf) begin
                     u_err = ST_OVERFLOW;
                  end else begin
                     u_sec = sec_wide[SEC_W-1:0];
                  end
               end else if (fcnt_ff < FCNT_W'(FRACTION_DIGITS)) begin
                  u_frac = frac_wide[FRAC_W-1:0];
                  u_fcnt = fcnt_ff + 1'b1;
               end
            end
            KIND_POINT: begin
               if (point_ff) begin
                  u_err = ST_SECOND_POINT;
               end else begin
                  u_point = 1'b1;
               end
            end
            default: begin
               u_lwd = 1'b0;
            end
         endcase
      end

      if (u_cnt > CNT_W'(MAX_CHARS)) begin
         u_stat = ST_TOO_LONG;
      end else if (u_err != ST_OK) begin
         u_stat = u_err;
      end else if (!u_point) begin
         u_stat = ST_NO_POINT;
      end else begin
         u_stat = ST_OK;
      end
   end

   always_comb begin
      sec_in   = sec_ff;
      frac_in  = frac_ff;
      fcnt_in  = fcnt_ff;
      point_in = point_ff;
      lwd_in   = lwd_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;
      if (item_pop) begin
         if (item.last) begin
            sec_in   = '0;
            frac_in  = '0;
            fcnt_in  = '0;
            point_in = 1'b0;
            lwd_in   = 1'b1;
            err_in   = ST_OK;
            cnt_in   = '0;
         end else begin
            sec_in   = u_sec;
            frac_in  = u_frac;
            fcnt_in  = u_fcnt;
            point_in = u_point;
            lwd_in   = u_lwd;
            err_in   = u_err;
            cnt_in   = u_cnt;
         end
      end
   end

   assign fin_stat_in  = u_stat;
   assign fin_sec_in   = (u_stat == ST_OK) ? u_sec : '0;
   assign fin_frac_in  = (u_stat == ST_OK) ? u_frac : '0;
   assign fin_k_in     = u_fcnt;
   assign fin_valid_in = fin_ready ? take_last : fin_valid_ff;

   assign ns_prod      = fin_frac_ff * pow10(NS_DIGITS - fin_k_ff);
   assign rsp_stat_in  = fin_stat_ff;
   assign rsp_sec_in   = fin_sec_ff;
   assign rsp_ns_in    = ns_prod[FRAC_W-1:0];
   assign rsp_valid_in = out_ready ? fin_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff       <= '0;
         frac_ff      <= '0;
         fcnt_ff      <= '0;
         point_ff     <= 1'b0;
         lwd_ff       <= 1'b1;
         err_ff       <= ST_OK;
         cnt_ff       <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sec_ff       <= sec_in;
         frac_ff      <= frac_in;
         fcnt_ff      <= fcnt_in;
         point_ff     <= point_in;
         lwd_ff       <= lwd_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_last) begin
         fin_stat_ff <= fin_stat_in;
         fin_sec_ff  <= fin_sec_in;
         fin_frac_ff <= fin_frac_in;
         fin_k_ff    <= fin_k_in;
      end
      if (out_ready && fin_valid_ff) begin
         rsp_stat_ff <= rsp_stat_in;
         rsp_sec_ff  <= rsp_sec_in;
         rsp_ns_ff   <= rsp_ns_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ns_ff, rsp_sec_ff, rsp_stat_ff};

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      take_last |=> (sec_ff == '0 && frac_ff == '0 && fcnt_ff == '0 && !point_ff
                     && lwd_ff && err_ff == ST_OK && cnt_ff == '0))
      else $error("parser state not cleared after a final character");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff != ST_OK) |-> (rsp_sec_ff == '0 && rsp_ns_ff == '0))
      else $error("invalid timestamp reports nonzero time");

   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ns_ff <= 30'd999999999))
      else $error("nanoseconds out of range");

   a_fcnt_limit: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= FCNT_W'(FRACTION_DIGITS))
      else $error("fraction digit count beyond limit");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !out_ready) |=> fin_valid_ff)
      else $error("finished timestamp dropped while output stalled");

endmodule

@@ hdl/ascii_timestamp_parser.sv @@
// Channel | Direction | Contents
// req_    | in        | tdata[7:0] = char_in, tlast = last_char
// rsp_    | out       | tdata[2:0] = status, [65:3] = seconds, [95:66] = nanoseconds
//
// One character is accepted per clock cycle, sustained, limited by the parser state update, while the queue has room.
// A final character passes through the character queue, then the fin_ and rsp_ result stages.
// Reset clears the character queue, the parser state and both result stages.
// A stalled output fills the result stages and then the four-entry queue before req_tready drops.
module ascii_timestamp_parser #(
   parameter int MAX_CHARS       = 30,
   parameter int FRACTION_DIGITS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // [2:0] status, [65:3] seconds, [95:66] nanoseconds
);
   import tsp_pkg::*;

   logic     item_valid;
   logic     item_pop;
   item_type item;

   tsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   tsp_back #(
      .MAX_CHARS       (MAX_CHARS),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
